[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 5;
  localparam int SPQ_DEPTH = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } shift_ctl_t;

endpackage

[rtl/core/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a key and moves it with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  shift_ctl_t              ctl,
  input  logic signed [KEY_W-1:0] new_key,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic                    left_gt,
  input  logic                    left_occ,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic                    occ,
  output logic signed [KEY_W-1:0] key_r,
  output logic                    gt
);

  logic signed [KEY_W-1:0] key_nxt;
  logic                    take_new;

  assign gt       = occ && (key_r > new_key);
  assign take_new = !left_gt && (occ ? gt : left_occ);

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (left_gt) begin
        key_nxt = left_key;
      end else if (take_new) begin
        key_nxt = new_key;
      end
    end else if (ctl.rem) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

[rtl/core/sorted_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted priority queue of signed keys built as a row of shifting cells.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge with start high; busy never
// rises, so one insert or remove can be issued in every cycle. Each
// transaction returns one result, strobed by out_valid for one cycle in the
// cycle after it was taken, showing the queue after that operation. The row
// of cells compares against the new key and shifts by one slot in a single
// step. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_op,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  output logic signed [KEY_W-1:0] out_front_key,
  output logic [COUNT_W-1:0]      out_count,
  output logic                    out_empty_res,
  output logic                    out_full_res,
  output logic                    out_rejected
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     valid_r, rejected_r, rejected_nxt;
  logic                     accept, is_empty, is_full;
  op_t                      op;
  shift_ctl_t               ctl;
  logic signed [KEY_W-1:0]  cell_key [DEPTH];
  logic                     cell_gt  [DEPTH];
  logic                     cell_occ [DEPTH];
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign op       = op_t'(in_op);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    ctl          = '0;
    count_nxt    = count_r;
    rejected_nxt = 1'b0;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          if (is_full) begin
            rejected_nxt = 1'b1;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (is_empty) begin
            rejected_nxt = 1'b1;
          end else begin
            ctl.rem   = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          rejected_nxt = 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;
    logic                    left_gt;
    logic                    left_occ;

    assign cell_occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_gt  = 1'b0;
      assign left_occ = 1'b1;
    end else begin : g_inner
      assign left_key = cell_key[i-1];
      assign left_gt  = cell_gt[i-1];
      assign left_occ = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_key   (in_key),
      .left_key  (left_key),
      .left_gt   (left_gt),
      .left_occ  (left_occ),
      .right_key (right_key),
      .occ       (cell_occ[i]),
      .key_r     (cell_key[i]),
      .gt        (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      valid_r    <= 1'b0;
      rejected_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      valid_r    <= accept;
      rejected_r <= rejected_nxt;
    end
  end

  assign count_ext     = {{COUNT_W{1'b0}}, count_r};
  assign out_valid     = valid_r;
  assign out_front_key = is_empty ? '0 : cell_key[0];
  assign out_count     = count_ext[COUNT_W-1:0];
  assign out_empty_res = is_empty;
  assign out_full_res  = is_full;
  assign out_rejected  = rejected_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

  a_reject_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> (is_empty || is_full))
    else $error("rejected transaction with queue neither empty nor full");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !rejected_r && $past(rst_n)) |-> (count_r != $past(count_r)))
    else $error("accepted transaction did not change count");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> $stable(count_r))
    else $error("count changed without a transaction");

endmodule
